[hdl/adld_pkg.sv]
// ----------------------------------------------------------------------------
// adld_pkg
// Shared widths, scale constants and types of the air data label decoder.
// ----------------------------------------------------------------------------
package adld_pkg;

  // fixed point format of the scaled value
  localparam int unsigned FRAC_BITS = 24;

  // field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VAL_W   = 41;
  localparam int unsigned RAW_W   = 19;
  localparam int unsigned DISC_W  = 3;
  localparam int unsigned BCD_W   = 17;

  localparam int unsigned OUT_FIELDS_W = LABEL_W + KIND_W + VAL_W + RAW_W;
  localparam int unsigned TDATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  // reciprocal scaling: value = (mag * K + 2^(S-1)) >> S
  // 2^S must exceed 2 * odd_divisor * magnitude for every label
  localparam int unsigned SCALE_SHIFT = 36;
  // largest scale is below 1/4
  localparam int unsigned K_W     = SCALE_SHIFT + FRAC_BITS - 2;
  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned NCHUNK  = (K_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned KPAD_W  = NCHUNK * CHUNK_W;
  localparam int unsigned PP_W    = RAW_W + CHUNK_W;
  localparam int unsigned SUM_W   = RAW_W + KPAD_W;
  localparam int unsigned MAGQ_W  = SUM_W - SCALE_SHIFT;
  // width for working out the constants at elaboration
  localparam int unsigned KC_W    = 20 + SCALE_SHIFT + FRAC_BITS;
  localparam int unsigned KSH     = SCALE_SHIFT + FRAC_BITS;

  // ceil(num * 2^(S+F) / den) for each scale group
  localparam logic [K_W-1:0] K_FT_M =
    K_W'(((KC_W'(381) << KSH) + KC_W'(2500 - 1)) / KC_W'(2500));
  localparam logic [K_W-1:0] K_MACH =
    K_W'(((KC_W'(1) << KSH) + KC_W'(65536 - 1)) / KC_W'(65536));
  localparam logic [K_W-1:0] K_KT_FINE =
    K_W'(((KC_W'(463) << KSH) + KC_W'(230400 - 1)) / KC_W'(230400));
  localparam logic [K_W-1:0] K_KT_COARSE =
    K_W'(((KC_W'(463) << KSH) + KC_W'(115200 - 1)) / KC_W'(115200));
  localparam logic [K_W-1:0] K_P9 =
    K_W'(((KC_W'(1) << KSH) + KC_W'(512 - 1)) / KC_W'(512));
  localparam logic [K_W-1:0] K_FPM =
    K_W'(((KC_W'(127) << KSH) + KC_W'(200000 - 1)) / KC_W'(200000));
  localparam logic [K_W-1:0] K_INHG =
    K_W'(((KC_W'(338639) << KSH) + KC_W'(40960000 - 1)) / KC_W'(40960000));
  localparam logic [K_W-1:0] K_P7 =
    K_W'(((KC_W'(1) << KSH) + KC_W'(128 - 1)) / KC_W'(128));
  localparam logic [K_W-1:0] K_P17 =
    K_W'(((KC_W'(1) << KSH) + KC_W'(131072 - 1)) / KC_W'(131072));
  localparam logic [K_W-1:0] K_BCD_MB =
    K_W'(((KC_W'(1) << KSH) + KC_W'(10 - 1)) / KC_W'(10));
  localparam logic [K_W-1:0] K_BCD_INHG =
    K_W'(((KC_W'(338639) << KSH) + KC_W'(10000000 - 1)) / KC_W'(10000000));

  typedef enum logic [KIND_W-1:0] {
    KIND_SCALED = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_NODATA = 2'd2
  } kind_e;

  // side information that rides along the arithmetic stages
  typedef struct packed {
    logic [LABEL_W-1:0]      label;
    kind_e                   kind;
    logic signed [RAW_W-1:0] raw_field;
    logic                    neg;
    logic                    use_mul;
    logic                    is_disc;
    logic [DISC_W-1:0]       disc;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    logic [RAW_W-1:0]   mag;
    logic [KPAD_W-1:0]  k;
  } dec_t;

  typedef logic [NCHUNK-1:0][PP_W-1:0] pp_vec_t;

endpackage

[hdl/adld_decode.sv]
// ----------------------------------------------------------------------------
// adld_decode
// Label decode, status check, magnitude and scale selection for one word.
// ----------------------------------------------------------------------------
module adld_decode (
  input  logic [adld_pkg::WORD_W-1:0] word_i,
  output adld_pkg::dec_t              dec_o
);

  typedef enum logic [1:0] {
    CLS_RAW,
    CLS_BNR,
    CLS_BCD,
    CLS_DISC
  } cls_e;

  localparam logic [1:0] SSM_NORM = 2'b11;
  localparam logic [1:0] SSM_PLUS = 2'b00;

  localparam logic [7:0] LBL_PRESS_ALT    = 8'o203;
  localparam logic [7:0] LBL_BARO_ALT     = 8'o204;
  localparam logic [7:0] LBL_MACH         = 8'o205;
  localparam logic [7:0] LBL_CAS          = 8'o206;
  localparam logic [7:0] LBL_VMAX         = 8'o207;
  localparam logic [7:0] LBL_TAS          = 8'o210;
  localparam logic [7:0] LBL_TAT          = 8'o211;
  localparam logic [7:0] LBL_ALT_RATE     = 8'o212;
  localparam logic [7:0] LBL_SAT          = 8'o213;
  localparam logic [7:0] LBL_TEMP_AUX     = 8'o215;
  localparam logic [7:0] LBL_STATIC_PRESS = 8'o217;
  localparam logic [7:0] LBL_BARO_ALT2    = 8'o220;
  localparam logic [7:0] LBL_TOTAL_PRESS  = 8'o242;
  localparam logic [7:0] LBL_FINE_PRESS   = 8'o244;
  localparam logic [7:0] LBL_ALT_AUX      = 8'o252;
  localparam logic [7:0] LBL_BARO_MB      = 8'o234;
  localparam logic [7:0] LBL_BARO_IN      = 8'o235;
  localparam logic [7:0] LBL_BARO_MB2     = 8'o236;
  localparam logic [7:0] LBL_BARO_IN2     = 8'o237;
  localparam logic [7:0] LBL_DISCRETE     = 8'o270;

  cls_e                            cls;
  logic [adld_pkg::K_W-1:0]        k_sel;
  logic [1:0]                      ssm;
  logic [adld_pkg::RAW_W-1:0]      rf;
  logic [adld_pkg::RAW_W-1:0]      rmag;
  logic                            rneg;
  logic [adld_pkg::BCD_W-1:0]      bcd_sum;

  assign ssm  = word_i[30:29];
  assign rf   = word_i[28:10];
  assign rneg = rf[adld_pkg::RAW_W-1];
  assign rmag = rneg ? (~rf + adld_pkg::RAW_W'(1)) : rf;

  // digits above nine are taken as they are
  assign bcd_sum = adld_pkg::BCD_W'(word_i[28:26]) * adld_pkg::BCD_W'(10000)
                 + adld_pkg::BCD_W'(word_i[25:22]) * adld_pkg::BCD_W'(1000)
                 + adld_pkg::BCD_W'(word_i[21:18]) * adld_pkg::BCD_W'(100)
                 + adld_pkg::BCD_W'(word_i[17:14]) * adld_pkg::BCD_W'(10)
                 + adld_pkg::BCD_W'(word_i[13:10]);

  always_comb begin
    cls   = CLS_RAW;
    k_sel = '0;
    case (word_i[7:0])
      LBL_PRESS_ALT, LBL_BARO_ALT, LBL_BARO_ALT2, LBL_ALT_AUX: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_FT_M;
      end
      LBL_MACH: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_MACH;
      end
      LBL_CAS, LBL_VMAX: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_KT_FINE;
      end
      LBL_TAS: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_KT_COARSE;
      end
      LBL_TAT, LBL_SAT, LBL_TEMP_AUX: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_P9;
      end
      LBL_ALT_RATE: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_FPM;
      end
      LBL_STATIC_PRESS: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_INHG;
      end
      LBL_TOTAL_PRESS: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_P7;
      end
      LBL_FINE_PRESS: begin
        cls   = CLS_BNR;
        k_sel = adld_pkg::K_P17;
      end
      LBL_BARO_MB, LBL_BARO_MB2: begin
        cls   = CLS_BCD;
        k_sel = adld_pkg::K_BCD_MB;
      end
      LBL_BARO_IN, LBL_BARO_IN2: begin
        cls   = CLS_BCD;
        k_sel = adld_pkg::K_BCD_INHG;
      end
      LBL_DISCRETE: begin
        cls = CLS_DISC;
      end
      default: begin
        cls = CLS_RAW;
      end
    endcase
  end

  always_comb begin
    dec_o.meta.label     = word_i[7:0];
    dec_o.meta.kind      = adld_pkg::KIND_NODATA;
    dec_o.meta.raw_field = rf;
    dec_o.meta.neg       = 1'b0;
    dec_o.meta.use_mul   = 1'b0;
    dec_o.meta.is_disc   = 1'b0;
    dec_o.meta.disc      = word_i[19:17];
    dec_o.mag            = '0;
    dec_o.k              = adld_pkg::KPAD_W'(k_sel);
    case (cls)
      CLS_BNR: begin
        if (ssm == SSM_NORM) begin
          dec_o.meta.kind    = adld_pkg::KIND_SCALED;
          dec_o.meta.use_mul = 1'b1;
          dec_o.meta.neg     = rneg;
          dec_o.mag          = rmag;
        end
      end
      CLS_BCD: begin
        // minus for normal status, plus for status zero
        if (ssm inside {SSM_NORM, SSM_PLUS}) begin
          dec_o.meta.kind    = adld_pkg::KIND_SCALED;
          dec_o.meta.use_mul = 1'b1;
          dec_o.meta.neg     = (ssm == SSM_NORM);
          dec_o.mag          = adld_pkg::RAW_W'(bcd_sum);
        end
      end
      CLS_DISC: begin
        dec_o.meta.kind    = adld_pkg::KIND_SCALED;
        dec_o.meta.is_disc = 1'b1;
      end
      default: begin
        dec_o.meta.kind = adld_pkg::KIND_RAW;
      end
    endcase
  end

endmodule

[hdl/adld_mult.sv]
// ----------------------------------------------------------------------------
// adld_mult
// Registered partial products of magnitude times the 32-bit scale slices.
// ----------------------------------------------------------------------------
module adld_mult (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [adld_pkg::RAW_W-1:0]  mag_i,
  input  logic [adld_pkg::KPAD_W-1:0] k_i,
  output adld_pkg::pp_vec_t           pp_o
);

  adld_pkg::pp_vec_t pp_d;
  adld_pkg::pp_vec_t pp_q;

  always_comb begin
    for (int i = 0; i < adld_pkg::NCHUNK; i++) begin
      pp_d[i] = adld_pkg::PP_W'(mag_i)
              * adld_pkg::PP_W'(k_i[i*adld_pkg::CHUNK_W +: adld_pkg::CHUNK_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
    end
  end

  assign pp_o = pp_q;

endmodule

[hdl/adld_round.sv]
// ----------------------------------------------------------------------------
// adld_round
// Sums the partial products with the half step and drops the reciprocal bits.
// ----------------------------------------------------------------------------
module adld_round (
  input  adld_pkg::pp_vec_t           pp_i,
  output logic [adld_pkg::MAGQ_W-1:0] mag_o
);

  logic [adld_pkg::SUM_W-1:0] sum;

  always_comb begin
    // half step gives round to nearest, ties away from zero on the magnitude
    sum = adld_pkg::SUM_W'(1) << (adld_pkg::SCALE_SHIFT - 1);
    for (int i = 0; i < adld_pkg::NCHUNK; i++) begin
      sum = sum + (adld_pkg::SUM_W'(pp_i[i]) << (i * adld_pkg::CHUNK_W));
    end
  end

  assign mag_o = sum[adld_pkg::SUM_W-1:adld_pkg::SCALE_SHIFT];

endmodule

[hdl/adld_sat.sv]
// ----------------------------------------------------------------------------
// adld_sat
// Clamps and signs the rounded magnitude and selects the final value.
// ----------------------------------------------------------------------------
module adld_sat (
  input  adld_pkg::meta_t                   meta_i,
  input  logic [adld_pkg::MAGQ_W-1:0]       mag_i,
  output logic signed [adld_pkg::VAL_W-1:0] value_o
);

  localparam logic [adld_pkg::MAGQ_W-1:0] NEG_LIM =
    adld_pkg::MAGQ_W'(1) << (adld_pkg::VAL_W - 1);
  localparam logic [adld_pkg::MAGQ_W-1:0] POS_LIM = NEG_LIM - adld_pkg::MAGQ_W'(1);

  logic [adld_pkg::MAGQ_W-1:0] mag_c;
  logic [adld_pkg::VAL_W-1:0]  mag_v;
  logic [adld_pkg::VAL_W-1:0]  scaled;

  always_comb begin
    mag_c = mag_i;
    if (meta_i.neg) begin
      if (mag_i > NEG_LIM) begin
        mag_c = NEG_LIM;
      end
    end else if (mag_i > POS_LIM) begin
      mag_c = POS_LIM;
    end
    mag_v  = mag_c[adld_pkg::VAL_W-1:0];
    scaled = meta_i.neg ? (~mag_v + adld_pkg::VAL_W'(1)) : mag_v;
  end

  always_comb begin
    if (meta_i.is_disc) begin
      value_o = adld_pkg::VAL_W'(meta_i.disc) << adld_pkg::FRAC_BITS;
    end else if (meta_i.use_mul) begin
      value_o = scaled;
    end else begin
      value_o = '0;
    end
  end

endmodule

[hdl/air_data_label_decoder.sv]
// ----------------------------------------------------------------------------
// air_data_label_decoder
// Decodes one 32-bit avionics data word per request into label, kind,
// fixed point engineering value and raw signed field.
// ----------------------------------------------------------------------------
// throughput: one request per cycle when not stalled, over five register stages
//   (input, decode, partial products, rounded magnitude, output)
// each stage moves on when it is empty or the next one moves on
// reset: asynchronous, active low, clears the stage valid flags only
// ----------------------------------------------------------------------------
module air_data_label_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [adld_pkg::WORD_W-1:0]  s_axis_tdata_i,   // [31:0] word
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [adld_pkg::TDATA_W-1:0] m_axis_tdata_o    // [7:0] label, [9:8] kind,
                                                         // [50:10] value,
                                                         // [69:51] raw_field,
                                                         // [71:70] zero
);

  localparam int unsigned NSTAGE = 5;

  // stage valid flags and the ready chain that runs back from the output
  logic [NSTAGE-1:0] valid_d;
  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE-1:0] rdy;

  // stage payloads
  logic [adld_pkg::WORD_W-1:0]       word_q;
  adld_pkg::dec_t                    dec;
  adld_pkg::dec_t                    dec_q;
  adld_pkg::meta_t                   meta3_q;
  adld_pkg::pp_vec_t                 pp;
  logic [adld_pkg::MAGQ_W-1:0]       mag_r;
  adld_pkg::meta_t                   meta4_q;
  logic [adld_pkg::MAGQ_W-1:0]       mag4_q;
  logic signed [adld_pkg::VAL_W-1:0] value;
  logic [adld_pkg::TDATA_W-1:0]      out_d;
  logic [adld_pkg::TDATA_W-1:0]      out_q;

  // a stage can take a new request when it is empty or its content moves on
  always_comb begin
    rdy[NSTAGE-1] = !valid_q[NSTAGE-1] || m_axis_tready_i;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    valid_d[0] = rdy[0] ? s_axis_tvalid_i : valid_q[0];
    for (int i = 1; i < NSTAGE; i++) begin
      valid_d[i] = rdy[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready_o = rdy[0];

  // input register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && rdy[0]) begin
      word_q <= s_axis_tdata_i;
    end
  end

  // label decode, status check, magnitude and scale pick
  adld_decode u_decode (
    .word_i (word_q),
    .dec_o  (dec)
  );

  always_ff @(posedge clk_i) begin
    if (valid_q[0] && rdy[1]) begin
      dec_q <= dec;
    end
  end

  // magnitude times scale, one partial product per 32-bit slice
  adld_mult u_mult (
    .clk_i (clk_i),
    .en_i  (valid_q[1] && rdy[2]),
    .mag_i (dec_q.mag),
    .k_i   (dec_q.k),
    .pp_o  (pp)
  );

  always_ff @(posedge clk_i) begin
    if (valid_q[1] && rdy[2]) begin
      meta3_q <= dec_q.meta;
    end
  end

  // sum of partial products, rounding, reciprocal shift
  adld_round u_round (
    .pp_i  (pp),
    .mag_o (mag_r)
  );

  always_ff @(posedge clk_i) begin
    if (valid_q[2] && rdy[3]) begin
      meta4_q <= meta3_q;
      mag4_q  <= mag_r;
    end
  end

  // clamp, sign and value select
  adld_sat u_sat (
    .meta_i  (meta4_q),
    .mag_i   (mag4_q),
    .value_o (value)
  );

  assign out_d = adld_pkg::TDATA_W'({meta4_q.raw_field, value, meta4_q.kind,
                                     meta4_q.label});

  // output register, holds while the result waits to be taken
  always_ff @(posedge clk_i) begin
    if (valid_q[3] && rdy[4]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = valid_q[NSTAGE-1];
  assign m_axis_tdata_o  = out_q;

endmodule

[hdl/adld_checker.sv]
// ----------------------------------------------------------------------------
// adld_checker
// Port-level checks of the air data label decoder, bound to the top level.
// ----------------------------------------------------------------------------
module adld_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_tvalid_i,
  input logic                         s_tready_i,
  input logic                         m_tvalid_i,
  input logic                         m_tready_i,
  input logic [adld_pkg::TDATA_W-1:0] m_tdata_i
);

  logic s_req;

  assign s_req = s_tvalid_i && s_tready_i;

  // a waiting result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  // input side stays open whenever the output register is free or drains
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_tvalid_i || m_tready_i) |-> s_tready_i)
    else $error("input stalled with free pipeline");

  // an accepted request reaches the output when the output never stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_req, 4) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1)
    && $past(m_tready_i, 3) && $past(m_tready_i, 2) && $past(m_tready_i, 1)
    && m_tready_i |=> m_tvalid_i)
    else $error("result missing after pipeline latency");

  // no result in the cycle after reset is seen
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_tvalid_i)
    else $error("result valid during reset");

endmodule

bind air_data_label_decoder adld_checker u_adld_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

[tb/sv/tb_air_data_label_decoder.sv]
// ----------------------------------------------------------------------------
// tb_air_data_label_decoder
// Self-checking bench for the air data label decoder: a queue-fed driver
// offers words in bursts, a monitor checks every decoded result in order
// against a behavioral decoder, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_air_data_label_decoder;

  // run control
  localparam int unsigned ITEM_COUNT     = 500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_TRIGGER   = 150;
  localparam int unsigned HOLD_CYCLES    = 300;

  // bit positions inside the result tdata
  localparam int unsigned KIND_LSB = adld_pkg::LABEL_W;
  localparam int unsigned VAL_LSB  = adld_pkg::LABEL_W + adld_pkg::KIND_W;
  localparam int unsigned RAW_LSB  = VAL_LSB + adld_pkg::VAL_W;

  // labels (octal, as the data bus defines them)
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_ALT_STD    = 8'o203;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_ALT_BARO   = 8'o204;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_ALT_RATE_S = 8'o220;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_ALT_SEL    = 8'o252;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_MACH       = 8'o205;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_CAS        = 8'o206;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_CAS_MAX    = 8'o207;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_TAS        = 8'o210;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_TAT        = 8'o211;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_SAT        = 8'o213;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_TEMP_AUX   = 8'o215;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_VSPEED     = 8'o212;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_PSTATIC    = 8'o217;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_AOA        = 8'o242;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_PTOTAL     = 8'o244;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_BCD_PS_MB  = 8'o234;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_BCD_QNH_MB = 8'o236;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_BCD_PS_IN  = 8'o235;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_BCD_QNH_IN = 8'o237;
  localparam logic [adld_pkg::LABEL_W-1:0] LBL_DISCRETE   = 8'o270;
  localparam int unsigned                  KNOWN_LABELS   = 20;

  // sign/status matrix codes
  localparam logic [1:0] SSM_NORMAL    = 2'b11;
  localparam logic [1:0] SSM_BCD_PLUS  = 2'b00;
  localparam logic [1:0] SSM_BCD_MINUS = 2'b11;
  localparam logic [1:0] SSM_NCD       = 2'b01;
  localparam logic [1:0] SSM_TEST      = 2'b10;

  localparam longint unsigned VALUE_MAX_POS = (64'd1 << (adld_pkg::VAL_W - 1)) - 64'd1;
  localparam longint unsigned VALUE_MAX_NEG = (64'd1 << (adld_pkg::VAL_W - 1));

  typedef enum int {
    GRP_RAW,
    GRP_BNR,
    GRP_BCD,
    GRP_DISC
  } label_grp_e;

  // one decoded word as it leaves the block, plus the source word for messages
  typedef struct {
    logic [adld_pkg::WORD_W-1:0]  word;
    logic [adld_pkg::LABEL_W-1:0] label;
    adld_pkg::kind_e              kind;
    logic [adld_pkg::VAL_W-1:0]   value;
    logic [adld_pkg::RAW_W-1:0]   raw_field;
  } decoded_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [adld_pkg::WORD_W-1:0]   s_data  = '0;

  // result side
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [adld_pkg::TDATA_W-1:0]  m_data;

  // words waiting to be offered, and decoded results waiting to come out
  logic [adld_pkg::WORD_W-1:0]   pending_words[$];
  decoded_t                      decoded_queue[$];

  // handshake bookkeeping
  logic                in_fire         = 1'b0;
  int unsigned         words_accepted  = 0;
  int unsigned         idle_cycles     = 0;
  int unsigned         err_count       = 0;

  // sender burst control, owned by the driver process
  int unsigned         burst_left = 1;
  int unsigned         gap_left   = 0;

  // receiver stall control, owned by the ready process
  int unsigned         hold_left  = 0;
  logic                hold_done  = 1'b0;
  logic [7:0]          rcv_cycle  = '0;

  air_data_label_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // behavioral decoder
  // --------------------------------------------------------------------------

  function automatic label_grp_e label_group(input logic [adld_pkg::LABEL_W-1:0] lab);
    case (lab)
      LBL_ALT_STD, LBL_ALT_BARO, LBL_ALT_RATE_S, LBL_ALT_SEL, LBL_MACH,
      LBL_CAS, LBL_CAS_MAX, LBL_TAS, LBL_TAT, LBL_SAT, LBL_TEMP_AUX,
      LBL_VSPEED, LBL_PSTATIC, LBL_AOA, LBL_PTOTAL: label_group = GRP_BNR;
      LBL_BCD_PS_MB, LBL_BCD_QNH_MB,
      LBL_BCD_PS_IN, LBL_BCD_QNH_IN:                label_group = GRP_BCD;
      LBL_DISCRETE:                                 label_group = GRP_DISC;
      default:                                      label_group = GRP_RAW;
    endcase
  endfunction

  // magnitude * num / den in fixed point, nearest with ties away from zero,
  // then signed and clamped to the value range
  function automatic logic [adld_pkg::VAL_W-1:0] scale_fixed(
      input longint unsigned mag,
      input bit neg,
      input longint unsigned num,
      input longint unsigned den);
    longint unsigned prod;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned frac;
    longint unsigned mfix;
    logic [63:0]     negv;
    prod = mag * num;
    quo  = prod / den;
    rem  = prod % den;
    frac = ((rem << adld_pkg::FRAC_BITS) * 64'd2 + den) / (den * 64'd2);
    mfix = (quo << adld_pkg::FRAC_BITS) + frac;
    if (neg) begin
      if (mfix > VALUE_MAX_NEG) mfix = VALUE_MAX_NEG;
      negv = 64'd0 - mfix;
      scale_fixed = negv[adld_pkg::VAL_W-1:0];
    end else begin
      if (mfix > VALUE_MAX_POS) mfix = VALUE_MAX_POS;
      scale_fixed = mfix[adld_pkg::VAL_W-1:0];
    end
  endfunction

  function automatic decoded_t decode_word(input logic [adld_pkg::WORD_W-1:0] w);
    decoded_t                   res;
    logic [1:0]                 ssm;
    logic [adld_pkg::RAW_W-1:0] field;
    bit                         fneg;
    longint unsigned            mag;
    longint unsigned            digits;
    longint unsigned            num;
    longint unsigned            den;
    logic [63:0]                disc;
    ssm   = w[30:29];
    field = w[28:10];
    fneg  = field[adld_pkg::RAW_W-1];
    mag   = fneg ? (64'h80000 - 64'(field)) : 64'(field);
    num   = 0;
    den   = 1;
    case (w[7:0])
      LBL_ALT_STD, LBL_ALT_BARO,
      LBL_ALT_RATE_S, LBL_ALT_SEL:         begin num = 381;    den = 2500;     end
      LBL_MACH:                            begin num = 1;      den = 65536;    end
      LBL_CAS, LBL_CAS_MAX:                begin num = 463;    den = 230400;   end
      LBL_TAS:                             begin num = 463;    den = 115200;   end
      LBL_TAT, LBL_SAT, LBL_TEMP_AUX:      begin num = 1;      den = 512;      end
      LBL_VSPEED:                          begin num = 127;    den = 200000;   end
      LBL_PSTATIC:                         begin num = 338639; den = 40960000; end
      LBL_AOA:                             begin num = 1;      den = 128;      end
      LBL_PTOTAL:                          begin num = 1;      den = 131072;   end
      LBL_BCD_PS_MB, LBL_BCD_QNH_MB:       begin num = 1;      den = 10;       end
      LBL_BCD_PS_IN, LBL_BCD_QNH_IN:       begin num = 338639; den = 10000000; end
      default: ;
    endcase
    res.word      = w;
    res.label     = w[7:0];
    res.raw_field = field;
    res.kind      = adld_pkg::KIND_NODATA;
    res.value     = '0;
    case (label_group(w[7:0]))
      GRP_BNR: begin
        // binary words only carry data with normal status
        if (ssm == SSM_NORMAL) begin
          res.kind  = adld_pkg::KIND_SCALED;
          res.value = scale_fixed(mag, fneg, num, den);
        end
      end
      GRP_BCD: begin
        // no computed data and functional test are rejected, digits above
        // nine keep their decade weight
        if (ssm == SSM_BCD_PLUS || ssm == SSM_BCD_MINUS) begin
          digits = 64'(w[28:26]) * 10000 + 64'(w[25:22]) * 1000
                 + 64'(w[21:18]) * 100 + 64'(w[17:14]) * 10 + 64'(w[13:10]);
          res.kind  = adld_pkg::KIND_SCALED;
          res.value = scale_fixed(digits, ssm == SSM_BCD_MINUS, num, den);
        end
      end
      GRP_DISC: begin
        disc      = 64'(w[19:17]) << adld_pkg::FRAC_BITS;
        res.kind  = adld_pkg::KIND_SCALED;
        res.value = disc[adld_pkg::VAL_W-1:0];
      end
      default: begin
        res.kind = adld_pkg::KIND_RAW;
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // parity bit 31 and sdi bits 9..8 come from noise
  function automatic logic [adld_pkg::WORD_W-1:0] pack_word(
      input logic [adld_pkg::LABEL_W-1:0] lab,
      input logic [1:0] ssm,
      input logic [adld_pkg::RAW_W-1:0] field,
      input logic [31:0] noise);
    return {noise[31], ssm, field, noise[9:8], lab};
  endfunction

  function automatic logic [adld_pkg::RAW_W-1:0] bcd_field(input logic [2:0] d4,
                                                           input logic [3:0] d3,
                                                           input logic [3:0] d2,
                                                           input logic [3:0] d1,
                                                           input logic [3:0] d0);
    return {d4, d3, d2, d1, d0};
  endfunction

  function automatic logic [adld_pkg::LABEL_W-1:0] pick_label(input int unsigned idx);
    case (idx)
      0:       pick_label = LBL_ALT_STD;
      1:       pick_label = LBL_ALT_BARO;
      2:       pick_label = LBL_ALT_RATE_S;
      3:       pick_label = LBL_ALT_SEL;
      4:       pick_label = LBL_MACH;
      5:       pick_label = LBL_CAS;
      6:       pick_label = LBL_CAS_MAX;
      7:       pick_label = LBL_TAS;
      8:       pick_label = LBL_TAT;
      9:       pick_label = LBL_SAT;
      10:      pick_label = LBL_TEMP_AUX;
      11:      pick_label = LBL_VSPEED;
      12:      pick_label = LBL_PSTATIC;
      13:      pick_label = LBL_AOA;
      14:      pick_label = LBL_PTOTAL;
      15:      pick_label = LBL_BCD_PS_MB;
      16:      pick_label = LBL_BCD_QNH_MB;
      17:      pick_label = LBL_BCD_PS_IN;
      18:      pick_label = LBL_BCD_QNH_IN;
      default: pick_label = LBL_DISCRETE;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v, input logic [31:0] word);
    err_count = err_count + 1;
    $display("mismatch %s: word %h got %h want %h", what, word, got_v, want_v);
  endtask

  // --------------------------------------------------------------------------
  // driver: offers queued words at the falling edge, in bursts with gaps
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // the word at the head went through at the last rising edge
      if (in_fire) begin
        void'(pending_words.pop_front());
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // about a third of bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        s_valid <= 1'b1;
        s_data  <= pending_words[0];
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: ready pattern changes with bits 7..6 of its counter, plus one long hold-off
  // while the sender keeps pushing so the pipeline fills and stalls its input
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rcv_cycle <= rcv_cycle + 8'd1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else if (!hold_done && words_accepted >= HOLD_TRIGGER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_ready   <= 1'b0;
      end else begin
        case (rcv_cycle[7:6])
          2'd0:    m_ready <= 1'b1;                        // no stalls
          2'd1:    m_ready <= ($urandom_range(0, 1) == 0); // coin flip
          2'd2:    m_ready <= (rcv_cycle[1:0] != 2'd0);    // one stall in four
          default: m_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: samples both handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    decoded_t got;
    decoded_t want;
    in_fire <= rst_ni && s_valid && s_ready;
    if (rst_ni) begin
      // check the result first: it can never belong to a word taken this edge
      if (m_valid && m_ready) begin
        got.label     = m_data[0 +: adld_pkg::LABEL_W];
        got.kind      = adld_pkg::kind_e'(m_data[KIND_LSB +: adld_pkg::KIND_W]);
        got.value     = m_data[VAL_LSB +: adld_pkg::VAL_W];
        got.raw_field = m_data[RAW_LSB +: adld_pkg::RAW_W];
        if (decoded_queue.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_data[63:0]), 64'd0, 32'd0);
        end else begin
          want = decoded_queue.pop_front();
          if (got.label !== want.label)
            report_mismatch("label", 64'(got.label), 64'(want.label), want.word);
          if (got.kind !== want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind), want.word);
          if (got.value !== want.value)
            report_mismatch("value", 64'(got.value), 64'(want.value), want.word);
          if (got.raw_field !== want.raw_field)
            report_mismatch("raw_field", 64'(got.raw_field), 64'(want.raw_field),
                            want.word);
        end
      end
      if (s_valid && s_ready) begin
        decoded_queue.push_back(decode_word(s_data));
        words_accepted <= words_accepted + 1;
      end
      if ((s_valid && s_ready) || (m_valid && m_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog: too long without any request or result moving
  initial begin
    wait (rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("air_data_label_decoder test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence: fill the queue, release reset, wait for the drain
  // --------------------------------------------------------------------------
  initial begin
    logic [adld_pkg::LABEL_W-1:0] lab;
    logic [1:0]                   ssm;
    logic [adld_pkg::RAW_W-1:0]   field;
    logic [adld_pkg::WORD_W-1:0]  word;
    label_grp_e                   grp;

    // directed: field extremes on the binary scales
    pending_words.push_back(pack_word(LBL_ALT_STD,  SSM_NORMAL, 19'h3ffff, 32'h0));
    pending_words.push_back(pack_word(LBL_ALT_STD,  SSM_NORMAL, 19'h40000, 32'hffffffff));
    pending_words.push_back(pack_word(LBL_MACH,     SSM_NORMAL, 19'h00001, 32'h0));
    pending_words.push_back(pack_word(LBL_CAS,      SSM_NORMAL, 19'h12345, 32'h0));
    pending_words.push_back(pack_word(LBL_TAS,      SSM_NORMAL, 19'h7ffff, 32'h0));
    pending_words.push_back(pack_word(LBL_TAT,      SSM_NORMAL, 19'h00000, 32'h0));
    pending_words.push_back(pack_word(LBL_VSPEED,   SSM_NORMAL, 19'h20000, 32'h0));
    pending_words.push_back(pack_word(LBL_PSTATIC,  SSM_NORMAL, 19'h3ffff, 32'h0));
    pending_words.push_back(pack_word(LBL_AOA,      SSM_NORMAL, 19'h40000, 32'h0));
    pending_words.push_back(pack_word(LBL_PTOTAL,   SSM_NORMAL, 19'h00001, 32'h0));
    // binary words with bad status
    pending_words.push_back(pack_word(LBL_ALT_SEL,  SSM_BCD_PLUS, 19'h3ffff, 32'h0));
    pending_words.push_back(pack_word(LBL_MACH,     SSM_NCD,      19'h11111, 32'h0));
    pending_words.push_back(pack_word(LBL_CAS_MAX,  SSM_TEST,     19'h40000, 32'h0));
    // bcd: plus, minus, no computed data, test, digits above nine, largest
    pending_words.push_back(pack_word(LBL_BCD_PS_MB, SSM_BCD_PLUS,
                                      bcd_field(3'd1, 4'd2, 4'd3, 4'd4, 4'd5), 32'h0));
    pending_words.push_back(pack_word(LBL_BCD_PS_MB, SSM_BCD_MINUS,
                                      bcd_field(3'd1, 4'd0, 4'd1, 4'd3, 4'd2), 32'h0));
    pending_words.push_back(pack_word(LBL_BCD_PS_IN, SSM_NCD,
                                      bcd_field(3'd2, 4'd9, 4'd9, 4'd2, 4'd1), 32'h0));
    pending_words.push_back(pack_word(LBL_BCD_QNH_IN, SSM_TEST,
                                      bcd_field(3'd3, 4'd0, 4'd0, 4'd0, 4'd0), 32'h0));
    pending_words.push_back(pack_word(LBL_BCD_QNH_MB, SSM_BCD_PLUS,
                                      bcd_field(3'd7, 4'd15, 4'd15, 4'd15, 4'd15),
                                      32'h0));
    pending_words.push_back(pack_word(LBL_BCD_QNH_IN, SSM_BCD_MINUS,
                                      bcd_field(3'd7, 4'd15, 4'd15, 4'd15, 4'd15),
                                      32'hffffffff));
    pending_words.push_back(pack_word(LBL_BCD_PS_IN, SSM_BCD_PLUS,
                                      bcd_field(3'd2, 4'd9, 4'd9, 4'd2, 4'd1), 32'h0));
    // discrete label, both extremes
    pending_words.push_back(pack_word(LBL_DISCRETE, SSM_TEST, 19'h00380, 32'h0));
    pending_words.push_back(pack_word(LBL_DISCRETE, SSM_NORMAL, 19'h7fc7f, 32'hffffffff));
    // labels with no decoding give the raw field only
    pending_words.push_back(32'h00000000);
    pending_words.push_back(32'hffffffff);
    pending_words.push_back(pack_word(8'h01, SSM_NORMAL, 19'h40000, 32'h0));

    // random: mostly well-formed words of known labels, the rest pure noise
    repeat (ITEM_COUNT) begin
      if ($urandom_range(0, 9) < 3) begin
        word = $urandom();
      end else begin
        lab = pick_label($urandom_range(0, KNOWN_LABELS - 1));
        grp = label_group(lab);
        if ($urandom_range(0, 3) != 0) begin
          if (grp == GRP_BCD)
            ssm = $urandom_range(0, 1) ? SSM_BCD_MINUS : SSM_BCD_PLUS;
          else
            ssm = SSM_NORMAL;
        end else begin
          ssm = 2'($urandom_range(0, 3));
        end
        if (grp == GRP_BCD && $urandom_range(0, 3) != 0)
          field = bcd_field(3'($urandom_range(0, 7)), 4'($urandom_range(0, 9)),
                            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                            4'($urandom_range(0, 9)));
        else
          field = 19'($urandom());
        word = pack_word(lab, ssm, field, $urandom());
      end
      pending_words.push_back(word);
    end

    // hold reset, then release it away from the rising edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // everything offered, taken and checked
    while (pending_words.size() != 0 || s_valid || decoded_queue.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("air_data_label_decoder test passed");
    end else begin
      $display("air_data_label_decoder test failed");
    end
    $finish;
  end

endmodule
